// ----- rtl/mbc1_pkg.sv -----
// Shared types, codes and constants for the MBC1 bank controller.
package mbc1_pkg;

	localparam int ACTION_W = 2;
	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;
	localparam int ROM_ADDR_W = 21;
	localparam int ROM_BANK_W = 7;
	localparam int LOW_BANK_W = 5;
	localparam int UPPER_BANK_W = 2;
	localparam int RAM_SIZE_W = 16;
	localparam int OFF_W = 16;
	localparam int BANKS_W = 3;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W = 16;
	localparam int RAM_BANK_BYTES = 8192;
	localparam int BANK_SHIFT = 13;
	localparam int ROM_OFF_W = 14;

	localparam logic [ACTION_W-1:0] ACT_ROM_RD = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_REG_WR = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RAM_RD = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_RAM_WR = 2'd3;

	localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANK_MASK = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RAM_SIZE_BYTES = 1'd1;

	localparam logic [ADDR_W-1:0] REG_GATE_END = 16'h2000;
	localparam logic [ADDR_W-1:0] REG_LOW_END = 16'h4000;
	localparam logic [ADDR_W-1:0] REG_UPPER_END = 16'h6000;
	localparam logic [ADDR_W-1:0] RAM_BASE = 16'hA000;
	localparam logic [3:0] GATE_OPEN_CODE = 4'hA;
	localparam logic [DATA_W-1:0] READ_MISS = 8'hFF;

	typedef struct packed {
		logic [ROM_ADDR_W-1:0] rom_address;
		logic                  ram_hit;
		logic [OFF_W-1:0]      store_addr;
		logic                  dirty_next;
	} dec_t;

	function automatic logic [UPPER_BANK_W-1:0] bank_wrap(
		input logic [UPPER_BANK_W-1:0] upper,
		input logic [BANKS_W-1:0]      banks
	);
		logic [BANKS_W-1:0] r;
		r = BANKS_W'(upper);
		for (int i = 0; i < 3; i++) begin
			if (r >= banks)
				r = r - banks;
		end
		return r[UPPER_BANK_W-1:0];
	endfunction

endpackage

// ----- rtl/mbc1_if.sv -----
// Request and response channel interfaces of the MBC1 bank controller.
interface mbc1_req_if;
	import mbc1_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [ADDR_W-1:0]   address;
	logic [DATA_W-1:0]   write_data;

	modport source (output valid, action, address, write_data, input ready);
	modport sink (input valid, action, address, write_data, output ready);
endinterface

interface mbc1_rsp_if;
	import mbc1_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [ROM_ADDR_W-1:0] rom_address;
	logic [DATA_W-1:0]     read_data;
	logic                  ram_access_taken;
	logic                  ram_dirty;

	modport source (output valid, rom_address, read_data, ram_access_taken, ram_dirty,
		input ready);
	modport sink (input valid, rom_address, read_data, ram_access_taken, ram_dirty,
		output ready);
endinterface

// ----- rtl/mbc1_regs.sv -----
// Bank, mode, gate and configuration registers with the access decode.
module mbc1_regs #(
	parameter int RAM_BYTES_MAX = 32768
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mbc1_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [mbc1_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               acc,
	input  logic [mbc1_pkg::ACTION_W-1:0]      action,
	input  logic [mbc1_pkg::ADDR_W-1:0]        address,
	input  logic [mbc1_pkg::DATA_W-1:0]        write_data,
	output mbc1_pkg::dec_t                     dec
);
	import mbc1_pkg::*;

	logic [ROM_BANK_W-1:0]   rom_mask_q;
	logic [RAM_SIZE_W-1:0]   ram_size_q;
	logic [LOW_BANK_W-1:0]   bank_lo_q;
	logic [UPPER_BANK_W-1:0] upper_bank_q;
	logic                    mode_q;
	logic                    gate_q;
	logic                    dirty_q;

	logic [RAM_SIZE_W-1:0]   fitted;
	logic [BANKS_W-1:0]      banks;
	logic [UPPER_BANK_W-1:0] ram_page;
	logic [OFF_W-1:0]        offset;
	logic                    hit;
	logic [ROM_BANK_W-1:0]   rom_bank;
	logic [LOW_BANK_W-1:0]   low_next;

	always_comb begin
		fitted = (ram_size_q > RAM_SIZE_W'(RAM_BYTES_MAX)) ? RAM_SIZE_W'(RAM_BYTES_MAX)
			: ram_size_q;
		banks = BANKS_W'(fitted >> BANK_SHIFT);
		ram_page = (mode_q && banks != '0) ? bank_wrap(upper_bank_q, banks) : '0;
		offset = (OFF_W'(ram_page) << BANK_SHIFT) + (address - RAM_BASE);
		hit = gate_q && fitted != '0 && address >= RAM_BASE && offset < fitted;

		if (address < REG_LOW_END)
			rom_bank = mode_q ? {upper_bank_q, LOW_BANK_W'(0)} : '0;
		else
			rom_bank = {upper_bank_q, bank_lo_q};
		rom_bank = rom_bank & rom_mask_q;

		dec.rom_address = (action == ACT_ROM_RD) ?
			{rom_bank, address[ROM_OFF_W-1:0]} : '0;
		dec.ram_hit = hit && (action == ACT_RAM_RD || action == ACT_RAM_WR);
		dec.store_addr = offset;
		dec.dirty_next = dirty_q || (hit && action == ACT_RAM_WR);

		low_next = write_data[LOW_BANK_W-1:0];
		if (low_next == '0)
			low_next = LOW_BANK_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_mask_q <= ROM_BANK_W'(1);
			ram_size_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROM_BANK_MASK:  rom_mask_q <= cfg_wdata[ROM_BANK_W-1:0];
				CFG_RAM_SIZE_BYTES: ram_size_q <= cfg_wdata[RAM_SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_lo_q <= LOW_BANK_W'(1);
			upper_bank_q <= '0;
			mode_q <= 1'b0;
			gate_q <= 1'b0;
			dirty_q <= 1'b0;
		end else if (acc) begin
			dirty_q <= dec.dirty_next;
			if (action == ACT_REG_WR) begin
				if (address < REG_GATE_END)
					gate_q <= (write_data[3:0] == GATE_OPEN_CODE);
				else if (address < REG_LOW_END)
					bank_lo_q <= low_next;
				else if (address < REG_UPPER_END)
					upper_bank_q <= write_data[UPPER_BANK_W-1:0];
				else
					mode_q <= write_data[0];
			end
		end
	end

	a_low_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		bank_lo_q != '0) else $error("low bank register holds zero");

	a_hit_needs_gate: assert property (@(posedge clk) disable iff (!arst_n)
		dec.ram_hit |-> gate_q && dec.store_addr < fitted)
		else $error("RAM hit outside open fitted RAM");

endmodule

// ----- rtl/mbc1_ram.sv -----
// Cartridge RAM with registered read and a zero-fill sweep after reset.
module mbc1_ram #(
	parameter int DEPTH = 32768,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rd_en,
	input  logic                         wr_en,
	input  logic [AW-1:0]                addr,
	input  logic [mbc1_pkg::DATA_W-1:0]  wdata,
	output logic [mbc1_pkg::DATA_W-1:0]  rdata,
	output logic                         busy
);
	import mbc1_pkg::*;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic              clr_q;
	logic [AW-1:0]     clr_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			if (clr_idx_q == AW'(DEPTH - 1))
				clr_q <= 1'b0;
			else
				clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q)
			mem_q[clr_idx_q] <= '0;
		else if (wr_en)
			mem_q[addr] <= wdata;
		if (rd_en)
			rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;
	assign busy = clr_q;

	a_idle_during_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !rd_en && !wr_en) else $error("RAM access during clear sweep");

	a_clear_advance: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q && clr_idx_q != AW'(DEPTH - 1) |=> clr_q && clr_idx_q == $past(clr_idx_q) + AW'(1))
		else $error("clear sweep skipped an entry");

endmodule

// ----- rtl/mbc1_bank_controller.sv -----
// Top level of the MBC1 bank controller: request stage, RAM read stage and output register.
// One cartridge bus access transfers per cycle while rsp.ready is high; its result passes
// through the RAM read stage and the output register to rsp, and the output register lets
// one more request transfer while a result waits. Register writes and RAM writes take
// effect for the very next access; the single-port RAM is read at the request transfer and
// its registered data is used in the RAM read stage. After reset the RAM is swept to zero,
// one byte a cycle, over all RAM_BYTES_MAX bytes (32768 by default); req.ready stays low
// for that time, configuration writes are taken throughout.
module mbc1_bank_controller #(
	parameter int RAM_BYTES_MAX = 32768
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mbc1_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [mbc1_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	mbc1_req_if.sink                         req,
	mbc1_rsp_if.source                       rsp
);
	import mbc1_pkg::*;

	localparam int RAM_AW = $clog2(RAM_BYTES_MAX);

	dec_t                  dec;
	logic                  acc;
	logic                  ram_busy;
	logic [DATA_W-1:0]     ram_rdata;
	logic                  out_free;

	logic                  valid_s1;
	logic [ACTION_W-1:0]   action_s1;
	logic [ROM_ADDR_W-1:0] rom_addr_s1;
	logic                  hit_s1;
	logic                  dirty_s1;

	logic                  out_valid_q;
	logic [ROM_ADDR_W-1:0] rom_addr_q;
	logic [DATA_W-1:0]     read_data_q;
	logic                  taken_q;
	logic                  dirty_q;
	logic [DATA_W-1:0]     read_data_s1;

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = !ram_busy && (!valid_s1 || out_free);
	assign acc = req.valid && req.ready;

	mbc1_regs #(
		.RAM_BYTES_MAX(RAM_BYTES_MAX)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.acc       (acc),
		.action    (req.action),
		.address   (req.address),
		.write_data(req.write_data),
		.dec       (dec)
	);

	mbc1_ram #(
		.DEPTH(RAM_BYTES_MAX),
		.AW   (RAM_AW)
	) u_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.rd_en (acc && req.action == ACT_RAM_RD && dec.ram_hit),
		.wr_en (acc && req.action == ACT_RAM_WR && dec.ram_hit),
		.addr  (dec.store_addr[RAM_AW-1:0]),
		.wdata (req.write_data),
		.rdata (ram_rdata),
		.busy  (ram_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (acc)
			valid_s1 <= 1'b1;
		else if (out_free)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			action_s1 <= req.action;
			rom_addr_s1 <= dec.rom_address;
			hit_s1 <= dec.ram_hit;
			dirty_s1 <= dec.dirty_next;
		end
	end

	always_comb begin
		if (action_s1 == ACT_RAM_RD)
			read_data_s1 = hit_s1 ? ram_rdata : READ_MISS;
		else
			read_data_s1 = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			rom_addr_q <= rom_addr_s1;
			read_data_q <= read_data_s1;
			taken_q <= hit_s1;
			dirty_q <= dirty_s1;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.rom_address = rom_addr_q;
	assign rsp.read_data = read_data_q;
	assign rsp.ram_access_taken = taken_q;
	assign rsp.ram_dirty = dirty_q;

	a_taken_no_rom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.ram_access_taken |-> rsp.rom_address == '0)
		else $error("RAM transfer carries a ROM address");

endmodule

// ----- sim/mbc1_access_checker.sv -----
// Checker for the MBC1 bank controller: predicts each bus access and compares the responses.
`timescale 1ns / 1ps

module mbc1_access_checker
	import mbc1_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata,
	mbc1_req_if                    req,
	mbc1_rsp_if                    rsp,
	output int                     mismatches,
	output int                     outstanding
);

	localparam int RAM_BYTES_MAX = 32768;

	typedef struct packed {
		logic [ROM_ADDR_W-1:0] rom_address;
		logic [DATA_W-1:0]     read_data;
		logic                  taken;
		logic                  dirty;
	} access_result_t;

	logic [ROM_BANK_W-1:0]   rom_mask;
	logic [RAM_SIZE_W-1:0]   ram_fitted;
	logic [LOW_BANK_W-1:0]   bank_lo;
	logic [UPPER_BANK_W-1:0] upper_bank;
	logic                    mode_bit;
	logic                    gate_open;
	logic                    dirty_seen;
	logic [DATA_W-1:0]       ram_image [0:RAM_BYTES_MAX-1];

	access_result_t expected_results[$];
	access_result_t got;
	access_result_t want;
	access_result_t predicted;
	int             miss_count;

	function automatic logic ram_window_hit(input logic [ADDR_W-1:0] addr,
		output logic [OFF_W-1:0] where);
		int size;
		int banks;
		int bank_sel;
		int off;
		where = '0;
		size = (int'(ram_fitted) > RAM_BYTES_MAX) ? RAM_BYTES_MAX : int'(ram_fitted);
		if (!gate_open || size == 0 || addr < RAM_BASE)
			return 1'b0;
		banks = size / RAM_BANK_BYTES;
		bank_sel = (mode_bit && banks != 0) ? int'(upper_bank) % banks : 0;
		off = bank_sel * RAM_BANK_BYTES + int'(addr) - int'(RAM_BASE);
		if (off >= size)
			return 1'b0;
		where = OFF_W'(off);
		return 1'b1;
	endfunction

	task automatic predict_access(input logic [ACTION_W-1:0] act,
		input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] wdata,
		output access_result_t res);
		logic [ROM_BANK_W-1:0] bank;
		logic [OFF_W-1:0]      where;
		logic                  hit;
		res = '0;
		case (act)
			ACT_ROM_RD: begin
				if (addr < REG_LOW_END)
					bank = mode_bit ? {upper_bank, 5'd0} : '0;
				else
					bank = {upper_bank, bank_lo};
				bank = bank & rom_mask;
				res.rom_address = {bank, addr[ROM_OFF_W-1:0]};
			end
			ACT_REG_WR: begin
				if (addr < REG_GATE_END) begin
					gate_open = (wdata[3:0] == GATE_OPEN_CODE);
				end else if (addr < REG_LOW_END) begin
					bank_lo = wdata[LOW_BANK_W-1:0];
					if (bank_lo == '0)
						bank_lo = 5'd1;
				end else if (addr < REG_UPPER_END) begin
					upper_bank = wdata[UPPER_BANK_W-1:0];
				end else begin
					mode_bit = wdata[0];
				end
			end
			ACT_RAM_RD: begin
				hit = ram_window_hit(addr, where);
				if (hit) begin
					res.read_data = ram_image[where];
					res.taken = 1'b1;
				end else begin
					res.read_data = READ_MISS;
				end
			end
			default: begin
				hit = ram_window_hit(addr, where);
				if (hit) begin
					ram_image[where] = wdata;
					dirty_seen = 1'b1;
					res.taken = 1'b1;
				end
			end
		endcase
		res.dirty = dirty_seen;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_mask = 7'd1;
			ram_fitted = '0;
			bank_lo = 5'd1;
			upper_bank = '0;
			mode_bit = 1'b0;
			gate_open = 1'b0;
			dirty_seen = 1'b0;
			for (int i = 0; i < RAM_BYTES_MAX; i++)
				ram_image[i] = '0;
			expected_results.delete();
			miss_count = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ROM_BANK_MASK)
					rom_mask = cfg_wdata[ROM_BANK_W-1:0];
				else if (cfg_index == CFG_RAM_SIZE_BYTES)
					ram_fitted = cfg_wdata[RAM_SIZE_W-1:0];
			end
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.rom_address, rsp.read_data, rsp.ram_access_taken, rsp.ram_dirty};
				if (expected_results.size() == 0) begin
					if (miss_count < 10)
						$display("unexpected result: rom %h rd %h taken %b dirty %b",
							got.rom_address, got.read_data, got.taken, got.dirty);
					miss_count++;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						if (miss_count < 10)
							$display({"mismatch: expected rom %h rd %h taken %b dirty %b, ",
								"got rom %h rd %h taken %b dirty %b"},
								want.rom_address, want.read_data, want.taken, want.dirty,
								got.rom_address, got.read_data, got.taken, got.dirty);
						miss_count++;
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_access(req.action, req.address, req.write_data, predicted);
				expected_results.push_back(predicted);
			end
			mismatches <= miss_count;
			outstanding <= expected_results.size();
		end
	end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the MBC1 bank controller: reset, register settings, bus traffic, verdict.
`timescale 1ns / 1ps

module tb;
	import mbc1_pkg::*;

	localparam int IDLE_LIMIT = 150000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 113;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	int                     mismatches;
	int                     outstanding;
	int                     idle_cycles;
	int                     sink_hold;
	int                     sink_next;
	logic                   source_eager;
	logic                   sink_eager;
	logic [ROM_BANK_W-1:0]  phase_mask;
	logic [RAM_SIZE_W-1:0]  phase_size;

	mbc1_req_if req();
	mbc1_rsp_if rsp();

	mbc1_bank_controller uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	mbc1_access_checker access_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_hold <= 0;
			rsp.ready <= 1'b0;
		end else begin
			sink_next = sink_hold;
			if (rsp.valid && rsp.ready)
				sink_next = sink_eager ? 0 : $urandom_range(0, 14);
			else if (sink_next > 0)
				sink_next = sink_next - 1;
			sink_hold <= sink_next;
			rsp.ready <= (sink_next == 0);
		end
	end

	task automatic program_settings(input logic [ROM_BANK_W-1:0] mask,
		input logic [RAM_SIZE_W-1:0] size);
		cfg_we <= 1'b1;
		cfg_index <= CFG_ROM_BANK_MASK;
		cfg_wdata <= CFG_DATA_W'(mask);
		@(posedge clk);
		cfg_index <= CFG_RAM_SIZE_BYTES;
		cfg_wdata <= size;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_access(input logic [ACTION_W-1:0] act, input logic [ADDR_W-1:0] addr,
		input logic [DATA_W-1:0] wdata);
		int gap;
		gap = source_eager ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.address <= addr;
		req.write_data <= wdata;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// hold the bus until every transfer has its response
	task automatic drain_results();
		req.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] pick_ram_address();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return ADDR_W'($urandom);
		else if (r < 6)
			return RAM_BASE + ADDR_W'($urandom_range(0, 15));
		else if (r == 6)
			return 16'hBFF0 + ADDR_W'($urandom_range(0, 15));
		else
			return RAM_BASE + ADDR_W'($urandom_range(0, 16'h1FFF));
	endfunction

	task automatic send_random_traffic(input int count);
		int sent;
		int burst;
		int r;
		logic [DATA_W-1:0] gate_byte;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 99) < 2)
				drain_results();
			if ($urandom_range(0, 9) < 6) begin
				gate_byte = DATA_W'($urandom);
				if ($urandom_range(0, 99) < 85)
					gate_byte[3:0] = GATE_OPEN_CODE;
				send_access(ACT_REG_WR, ADDR_W'($urandom_range(0, 16'h1FFF)), gate_byte);
				send_access(ACT_REG_WR, REG_LOW_END + ADDR_W'($urandom_range(0, 16'h1FFF)),
					DATA_W'($urandom));
				send_access(ACT_REG_WR, REG_UPPER_END + ADDR_W'($urandom_range(0, 16'h9FFF)),
					DATA_W'($urandom));
				burst = $urandom_range(3, 8);
				for (int k = 0; k < burst; k++) begin
					r = $urandom_range(0, 9);
					if (r < 2)
						send_access(ACT_ROM_RD, ADDR_W'($urandom), DATA_W'($urandom));
					else if (r == 2)
						send_access(ACT_REG_WR,
							REG_GATE_END + ADDR_W'($urandom_range(0, 16'h1FFF)),
							DATA_W'($urandom));
					else if (r < 7)
						send_access(ACT_RAM_WR, pick_ram_address(), DATA_W'($urandom));
					else
						send_access(ACT_RAM_RD, pick_ram_address(), DATA_W'($urandom));
				end
				sent += 3 + burst;
			end else begin
				send_access(ACTION_W'($urandom), ADDR_W'($urandom), DATA_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		req.valid <= 1'b0;
		req.action <= ACT_ROM_RD;
		req.address <= '0;
		req.write_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_ROM_BANK_MASK;
		cfg_wdata <= '0;
		arst_n <= 1'b0;
		source_eager = 1'b0;
		sink_eager = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		program_settings(7'd127, 16'd32768);

		send_access(ACT_ROM_RD, 16'h0000, 8'h00);
		send_access(ACT_ROM_RD, 16'h7FFF, 8'hFF);
		send_access(ACT_ROM_RD, 16'hFFFF, 8'h00);
		send_access(ACT_RAM_RD, 16'hA000, 8'h00);
		send_access(ACT_REG_WR, 16'h0000, 8'h0A);
		send_access(ACT_RAM_WR, 16'hA000, 8'hFF);
		send_access(ACT_RAM_RD, 16'hA000, 8'h00);
		send_access(ACT_RAM_RD, 16'h9FFF, 8'h00);
		send_access(ACT_RAM_WR, 16'hBFFF, 8'h5A);
		send_access(ACT_REG_WR, 16'h2000, 8'h00);
		send_access(ACT_ROM_RD, 16'h4000, 8'h00);
		send_access(ACT_REG_WR, 16'h3FFF, 8'hFF);
		send_access(ACT_REG_WR, 16'h4000, 8'hFF);
		send_access(ACT_ROM_RD, 16'h5555, 8'h00);
		send_access(ACT_REG_WR, 16'h6000, 8'h01);
		send_access(ACT_ROM_RD, 16'h1234, 8'h00);
		send_access(ACT_RAM_WR, 16'hA001, 8'hC3);
		send_access(ACT_RAM_RD, 16'hA001, 8'h00);
		send_access(ACT_RAM_RD, 16'hC000, 8'h00);
		send_access(ACT_REG_WR, 16'hFFFF, 8'hFE);
		send_access(ACT_RAM_RD, 16'hA001, 8'h00);
		send_access(ACT_REG_WR, 16'h1FFF, 8'h1B);
		send_access(ACT_RAM_WR, 16'hA002, 8'h11);
		send_access(ACT_REG_WR, 16'h0000, 8'hFA);
		send_access(ACT_RAM_RD, 16'hBFFF, 8'h00);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			case (phase)
				0: begin phase_mask = 7'd1; phase_size = 16'd0; end
				1: begin phase_mask = 7'd127; phase_size = 16'd65535; end
				2: begin phase_mask = 7'd31; phase_size = 16'd2048; end
				3: begin phase_mask = 7'd3; phase_size = 16'd8192; end
				4: begin phase_mask = 7'd63; phase_size = 16'd24576; end
				5: begin phase_mask = 7'd15; phase_size = 16'd16384; end
				6: begin phase_mask = 7'd127; phase_size = 16'd32768; end
				default: begin
					phase_mask = ROM_BANK_W'($urandom_range(1, 127));
					if ($urandom_range(0, 1) == 1)
						phase_size = RAM_SIZE_W'(RAM_BANK_BYTES * $urandom_range(0, 5));
					else
						phase_size = RAM_SIZE_W'($urandom);
				end
			endcase
			source_eager = (phase % 3 == 1);
			sink_eager = (phase % 4 == 2);
			program_settings(phase_mask, phase_size);
			send_random_traffic(PHASE_ITEMS);
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
